### hw/rtl/hlfa_pkg.sv
// ----------------------------------------------------------------------------
// hlfa_pkg
// Shared constants and types for the hole list allocator.
// ----------------------------------------------------------------------------
package hlfa_pkg;

    localparam int MEM_WORDS  = 1048576;
    localparam int MAX_HOLES  = 64;
    localparam int ADDR_W     = 20;
    localparam int SIZE_W     = 21;
    localparam int IDX_W      = $clog2(MAX_HOLES);
    localparam int CNT_W      = $clog2(MAX_HOLES + 1);
    localparam int ENTRY_W    = ADDR_W + SIZE_W;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_APPLY,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_UPD,
        S_OUT
    } state_t;

endpackage

### hw/rtl/hlfa_ram.sv
// ----------------------------------------------------------------------------
// hlfa_ram
// Single port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module hlfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/hole_list_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// hole_list_fit_allocator_core
// Free hole list allocator with first, best and worst fit policies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): mode, block_size, block_start. One result
//   item (status, granted_start) comes back per input item on the output
//   channel (valid/stall). Config channel (valid/ready) writes fit_policy;
//   the user must do this only while the block is idle (not enforced).
//   The hole list sits in one RAM (base and length per entry, one port,
//   registered read). One item is in flight at a time. The scan reads
//   entries 0..count-1 one per cycle. A refused or ignored item then
//   goes to the output from S_APPLY, an in-place update through S_UPD.
//   An insert or erase shifts the tail one moved entry at a time, with a
//   read and a write state per entry. The next item is taken once the
//   result has left and the block is back in S_IDLE.
//   Reset: list holds one hole covering all of memory, policy first fit.
//   Until entry 0 is first written, reads of it return the reset hole.
//   When the receiver stalls, the result holds in the output register and
//   no new item is taken until it is delivered.
// ----------------------------------------------------------------------------
module hole_list_fit_allocator_core
    import hlfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [SIZE_W-1:0] block_size,
    input  logic [ADDR_W-1:0] block_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] granted_start,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    state_t state_reg, state_next;
    logic [1:0]        policy_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              e0_ovr_reg, e0_ovr_next;
    logic              mode_reg, mode_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [SIZE_W-1:0] best_reg, best_next;
    logic [ADDR_W-1:0] pbase_reg, pbase_next;
    logic [SIZE_W-1:0] plen_reg, plen_next;
    logic              fpos_reg, fpos_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              hbv_reg, hbv_next;
    logic [ADDR_W-1:0] bbase_reg, bbase_next;
    logic [SIZE_W-1:0] blen_reg, blen_next;
    logic              hav_reg, hav_next;
    logic [ADDR_W-1:0] abase_reg, abase_next;
    logic [SIZE_W-1:0] alen_reg, alen_next;
    logic [1:0]        st_reg, st_next;
    logic [ADDR_W-1:0] gs_reg, gs_next;
    logic              ov_reg, ov_next;
    // pending single entry write (after any shift)
    logic [IDX_W-1:0]  uaddr_reg, uaddr_next;
    logic [ENTRY_W-1:0] udata_reg, udata_next;

    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] wdata, rraw;
    logic [ADDR_W-1:0]  rbase;
    logic [SIZE_W-1:0]  rlen;
    logic [CNT_W-1:0]   ridx_reg;

    hlfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_HOLES)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
    );

    always_comb
    begin
        if (e0_ovr_reg && ridx_reg == '0)
        begin
            rbase = '0;
            rlen  = SIZE_W'(MEM_WORDS);
        end
        else
        begin
            rbase = rraw[ENTRY_W-1:SIZE_W];
            rlen  = rraw[SIZE_W-1:0];
        end
    end

    assign in_stall      = (state_reg != S_IDLE) || ov_reg;
    assign cfg_ready     = 1'b1;
    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign granted_start = gs_reg;

    logic [ADDR_W:0]   bend, nend;
    logic [SIZE_W-1:0] left;
    logic              take;
    logic [SIZE_W:0]   sum2;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        e0_ovr_next = e0_ovr_reg;
        mode_next = mode_reg;  size_next = size_reg;  start_next = start_reg;
        k_next = k_reg;  found_next = found_reg;  pick_next = pick_reg;
        best_next = best_reg;  pbase_next = pbase_reg;  plen_next = plen_reg;
        fpos_next = fpos_reg;  pos_next = pos_reg;
        hbv_next = hbv_reg;  bbase_next = bbase_reg;  blen_next = blen_reg;
        hav_next = hav_reg;  abase_next = abase_reg;  alen_next = alen_reg;
        st_next = st_reg;  gs_next = gs_reg;  ov_next = ov_reg;
        uaddr_next = uaddr_reg;  udata_next = udata_reg;
        we = 1'b0;  addr = '0;  wdata = '0;
        bend = {1'b0, bbase_reg} + blen_reg;
        nend = {1'b0, start_reg} + size_reg[ADDR_W:0];
        left = rlen - size_reg;
        take = 1'b0;
        sum2 = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    mode_next = mode;  size_next = block_size;  start_next = block_start;
                    k_next = '0;  found_next = 1'b0;  fpos_next = 1'b0;
                    pos_next = count_reg;  hbv_next = 1'b0;  hav_next = 1'b0;
                    addr = '0;
                    if (count_reg == '0)
                        state_next = S_SCAN_LAST;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mode_reg == OP_ALLOC)
                begin
                    if (rlen >= size_reg && !(found_reg && policy_reg != POL_BEST
                        && policy_reg != POL_WORST))
                    begin
                        if (policy_reg == POL_BEST)
                            take = !found_reg || left < best_reg;
                        else if (policy_reg == POL_WORST)
                            take = !found_reg || left > best_reg;
                        else
                            take = 1'b1;
                    end
                    if (take)
                    begin
                        found_next = 1'b1;  pick_next = ridx_reg[IDX_W-1:0];
                        best_next = left;  pbase_next = rbase;  plen_next = rlen;
                    end
                end
                else if (!fpos_reg)
                begin
                    if (rbase <= start_reg)
                    begin
                        hbv_next = 1'b1;  bbase_next = rbase;  blen_next = rlen;
                    end
                    else
                    begin
                        fpos_next = 1'b1;  pos_next = ridx_reg;
                        hav_next = 1'b1;  abase_next = rbase;  alen_next = rlen;
                    end
                end
                k_next = ridx_reg + 1'b1;
                addr = k_next[IDX_W-1:0];
                if (k_next == count_reg)
                    state_next = S_SCAN_LAST;
            end
            S_SCAN_LAST:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                st_next = ST_DONE;  gs_next = '0;
                state_next = S_OUT;
                if (mode_reg == OP_ALLOC)
                begin
                    if (size_reg == '0 || !found_reg)
                        st_next = ST_NOFIT;
                    else
                    begin
                        gs_next = pbase_reg;
                        if (plen_reg == size_reg)
                        begin
                            k_next = {1'b0, pick_reg};
                            state_next = S_SHL_RD;
                        end
                        else
                        begin
                            uaddr_next = pick_reg;
                            udata_next = {pbase_reg + size_reg[ADDR_W-1:0],
                                          plen_reg - size_reg};
                            state_next = S_UPD;
                        end
                    end
                end
                else if (size_reg == '0 || size_reg > SIZE_W'(MEM_WORDS) ||
                         ({1'b0, start_reg} + size_reg) > (SIZE_W+1)'(MEM_WORDS))
                begin
                end
                else if (hbv_reg && bend > {1'b0, start_reg})
                begin
                end
                else if (hav_reg && nend > {1'b0, abase_reg})
                begin
                end
                else if (hbv_reg && bend == {1'b0, start_reg}
                         && hav_reg && nend == {1'b0, abase_reg})
                begin
                    sum2 = blen_reg + size_reg + alen_reg;
                    uaddr_next = IDX_W'(pos_reg - 1'b1);
                    udata_next = {bbase_reg, sum2[SIZE_W-1:0]};
                    k_next = pos_reg;
                    state_next = S_SHL_RD;
                end
                else if (hbv_reg && bend == {1'b0, start_reg})
                begin
                    uaddr_next = IDX_W'(pos_reg - 1'b1);
                    udata_next = {bbase_reg, blen_reg + size_reg};
                    state_next = S_UPD;
                end
                else if (hav_reg && nend == {1'b0, abase_reg})
                begin
                    uaddr_next = pos_reg[IDX_W-1:0];
                    udata_next = {start_reg, alen_reg + size_reg};
                    state_next = S_UPD;
                end
                else if (count_reg >= CNT_W'(MAX_HOLES))
                    st_next = ST_FULL;
                else
                begin
                    uaddr_next = pos_reg[IDX_W-1:0];
                    udata_next = {start_reg, size_reg};
                    k_next = count_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_SHR_RD;
                end
                if (state_next == S_OUT)
                    ov_next = 1'b1;
            end
            S_SHL_RD:
            begin
                // move entry k+1 down to k
                if (k_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = (mode_reg == OP_RELEASE) ? S_UPD : S_OUT;
                    if (mode_reg == OP_ALLOC)
                        ov_next = 1'b1;
                end
                else
                begin
                    addr = IDX_W'(k_reg + 1'b1);
                    state_next = S_SHL_WR;
                end
            end
            S_SHL_WR:
            begin
                we = 1'b1;  addr = k_reg[IDX_W-1:0];  wdata = {rbase, rlen};
                if (k_reg == '0) e0_ovr_next = 1'b0;
                k_next = k_reg + 1'b1;
                state_next = S_SHL_RD;
            end
            S_SHR_RD:
            begin
                // k_reg is destination; copy k-1 into k
                if (k_reg[IDX_W-1:0] == uaddr_reg && k_reg <= CNT_W'(MAX_HOLES - 1))
                    state_next = S_UPD;
                else
                begin
                    addr = IDX_W'(k_reg - 1'b1);
                    state_next = S_SHR_WR;
                end
            end
            S_SHR_WR:
            begin
                we = 1'b1;  addr = k_reg[IDX_W-1:0];  wdata = {rbase, rlen};
                k_next = k_reg - 1'b1;
                state_next = S_SHR_RD;
            end
            S_UPD:
            begin
                we = 1'b1;  addr = uaddr_reg;  wdata = udata_reg;
                if (uaddr_reg == '0) e0_ovr_next = 1'b0;
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            policy_reg <= POL_FIRST;
            count_reg  <= CNT_W'(1);
            e0_ovr_reg <= 1'b1;
            ov_reg     <= 1'b0;
            ridx_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            e0_ovr_reg <= e0_ovr_next;
            ov_reg     <= ov_next;
            ridx_reg   <= {1'b0, addr};
            if (cfg_valid && cfg_ready)
                policy_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;  size_reg <= size_next;  start_reg <= start_next;
        k_reg <= k_next;  found_reg <= found_next;  pick_reg <= pick_next;
        best_reg <= best_next;  pbase_reg <= pbase_next;  plen_reg <= plen_next;
        fpos_reg <= fpos_next;  pos_reg <= pos_next;
        hbv_reg <= hbv_next;  bbase_reg <= bbase_next;  blen_reg <= blen_next;
        hav_reg <= hav_next;  abase_reg <= abase_next;  alen_reg <= alen_next;
        st_reg <= st_next;  gs_reg <= gs_next;
        uaddr_reg <= uaddr_next;  udata_reg <= udata_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_HOLES)) else $error("hole count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(st_reg)) else $error("result lost");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall) else $error("accept while busy");
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && st_reg != ST_DONE |-> gs_reg == '0) else $error("grant on failure");

endmodule
